>>> hw/rtl/hed_pkg.sv
// Shared types, character codes and lookup functions of the entity decoder.
package hed_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_NAME,
        ST_NUM_WS,
        ST_NUM_SIGN,
        ST_NUM_PFX,
        ST_NUM_DIG,
        ST_NUM_END,
        ST_EXPAND,
        ST_FLUSH
    } t_state;

    typedef struct packed {
        logic [7:0] data;
        logic       eot;
    } t_item;

    typedef struct packed {
        logic            hit;
        logic [1:0]      n;
        logic [2:0][7:0] b;
    } t_ent;

    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_XL    = 8'h78;
    localparam logic [7:0] CH_XU    = 8'h58;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam int         NUM_ENT  = 67;
    localparam logic [4:0] DIG_NONE = 5'd31;

    // Names right-justified, first character in the highest used byte.
    localparam logic [47:0] ENT_NAME [NUM_ENT] = '{
        "amp", "lt", "gt", "quot", "apos", "nbsp", "shy",
        "aacute", "agrave", "acirc", "atilde", "auml",
        "Aacute", "Agrave", "Acirc", "Atilde", "Auml",
        "ccedil", "Ccedil",
        "eacute", "egrave", "ecirc", "euml",
        "Eacute", "Egrave", "Ecirc", "Euml",
        "iacute", "igrave", "icirc", "iuml",
        "Iacute", "Igrave", "Icirc", "Iuml",
        "oacute", "ograve", "ocirc", "otilde", "ouml",
        "Oacute", "Ograve", "Ocirc", "Otilde", "Ouml",
        "uacute", "ugrave", "ucirc", "uuml",
        "Uacute", "Ugrave", "Ucirc", "Uuml",
        "ntilde", "Ntilde",
        "laquo", "raquo",
        "ordf", "ordm", "deg",
        "ndash", "mdash", "hellip",
        "lsquo", "rsquo", "ldquo", "rdquo"
    };

    // Replacement bytes, right-justified; zero means no bytes.
    localparam logic [23:0] ENT_VAL [NUM_ENT] = '{
        24'h26, 24'h3C, 24'h3E, 24'h22, 24'h27, 24'h20, 24'h00,
        24'hE1, 24'hE0, 24'hE2, 24'hE3, 24'hE4,
        24'hC1, 24'hC0, 24'hC2, 24'hC3, 24'hC4,
        24'hE7, 24'hC7,
        24'hE9, 24'hE8, 24'hEA, 24'hEB,
        24'hC9, 24'hC8, 24'hCA, 24'hCB,
        24'hED, 24'hEC, 24'hEE, 24'hEF,
        24'hCD, 24'hCC, 24'hCE, 24'hCF,
        24'hF3, 24'hF2, 24'hF4, 24'hF5, 24'hF6,
        24'hD3, 24'hD2, 24'hD4, 24'hD5, 24'hD6,
        24'hFA, 24'hF9, 24'hFB, 24'hFC,
        24'hDA, 24'hD9, 24'hDB, 24'hDC,
        24'hF1, 24'hD1,
        24'hAB, 24'hBB,
        24'hAA, 24'hBA, 24'hB0,
        24'h2D, 24'h2D, 24'h2E2E2E,
        24'h27, 24'h27, 24'h22, 24'h22
    };

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic [4:0] digit_val(input logic [7:0] c);
        logic [4:0] d;
        d = DIG_NONE;
        if (c >= 8'h30 && c <= 8'h39) d = 5'(c - 8'h30);
        else if (c >= 8'h61 && c <= 8'h66) d = 5'(c - 8'h57);
        else if (c >= 8'h41 && c <= 8'h46) d = 5'(c - 8'h37);
        return d;
    endfunction

    function automatic t_ent ent_lookup(input logic [5:0][7:0] body, input logic [7:0] len);
        t_ent        r;
        logic [47:0] nm;
        logic [23:0] v;
        int          nl;
        int          vl;
        logic        ok;
        r = '0;
        for (int k = 0; k < NUM_ENT; k++) begin
            nm = ENT_NAME[k];
            v  = ENT_VAL[k];
            nl = 0;
            vl = 0;
            for (int j = 0; j < 6; j++) if (nm[8*j +: 8] != 8'h00) nl = j + 1;
            for (int j = 0; j < 3; j++) if (v[8*j +: 8] != 8'h00) vl = j + 1;
            ok = (len == 8'(nl));
            for (int i = 0; i < 6; i++) begin
                if (i < nl && body[i] != nm[8*(nl-1-i) +: 8]) ok = 1'b0;
            end
            if (ok && !r.hit) begin
                r.hit = 1'b1;
                r.n   = 2'(vl);
                for (int j = 0; j < 3; j++) begin
                    if (j < vl) r.b[j] = v[8*(vl-1-j) +: 8];
                end
            end
        end
        return r;
    endfunction

endpackage

>>> hw/rtl/hed_front.sv
// Input side of the entity decoder: accepts bytes into a two-entry queue.
module hed_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  logic [7:0]     i_in_byte,
    input  logic           i_end_of_text,
    output logic           o_item_valid,
    output hed_pkg::t_item o_item,
    input  logic           i_item_take
);

    hed_pkg::t_item r_q [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;
    logic           w_push;

    assign o_in_ready   = (r_cnt != 2'd2);
    assign w_push       = i_in_valid && o_in_ready;
    assign o_item_valid = (r_cnt != 2'd0);
    assign o_item       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (i_item_take) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(i_item_take);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp].data <= i_in_byte;
            r_q[r_wp].eot  <= i_end_of_text;
        end
    end

endmodule

>>> hw/rtl/hed_back.sv
// Decode engine: lookahead buffer, name and number decoding, output staging.
module hed_back #(
    parameter int SEMI_WINDOW = 10
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_item_valid,
    input  hed_pkg::t_item i_item,
    output logic           o_item_take,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output logic [7:0]     o_out_byte,
    output logic           o_run_last
);

    localparam int BUF_DEPTH = SEMI_WINDOW + 1;
    localparam int CNT_W     = $clog2(BUF_DEPTH + 1);
    localparam int IDX_W     = $clog2(BUF_DEPTH);

    hed_pkg::t_state r_state, n_state;

    logic [7:0]       r_buf [BUF_DEPTH];
    logic [7:0]       n_buf [BUF_DEPTH];
    logic [CNT_W-1:0] r_cnt;
    logic             r_eot;
    logic [CNT_W-1:0] r_found;
    logic [7:0]       r_p [BUF_DEPTH];
    logic [CNT_W-1:0] r_plen;
    logic             r_hex;
    logic             r_neg;
    logic             r_ovf;
    logic [31:0]      r_acc;
    logic [2:0][7:0]  r_exp;
    logic [1:0]       r_exp_n;
    logic [1:0]       r_exp_i;
    logic [CNT_W-1:0] r_drop;
    logic             r_pend_v;
    logic [7:0]       r_pend;
    logic             r_out_v;
    logic [7:0]       r_out;
    logic             r_last;

    logic             w_found_v;
    logic [CNT_W-1:0] w_found;
    logic             w_is_num;
    logic             w_hex;
    logic             w_out_free;
    logic             w_can_emit;
    logic             w_do_emit;
    logic [7:0]       w_emit_byte;
    logic             w_drop_en;
    logic [CNT_W-1:0] w_drop_n;
    logic             w_flush_out;
    logic [5:0][7:0]  w_body;
    hed_pkg::t_ent    w_ent;
    logic [31:0]      w_cp;
    logic [2:0][7:0]  w_utf;
    logic [1:0]       w_utf_n;
    logic [4:0]       w_dig;
    logic             w_dig_ok;
    logic [36:0]      w_acc_next;
    logic             w_amp_head;

    // First ';' after the head byte, lowest position wins.
    always_comb begin
        w_found_v = 1'b0;
        w_found   = '0;
        for (int s = BUF_DEPTH - 1; s >= 1; s--) begin
            if (CNT_W'(s) < r_cnt && r_buf[s] == hed_pkg::CH_SEMI) begin
                w_found_v = 1'b1;
                w_found   = CNT_W'(s);
            end
        end
    end

    assign w_amp_head = (r_cnt != '0) && (r_buf[0] == hed_pkg::CH_AMP);
    assign w_is_num   = (w_found >= CNT_W'(3)) && (r_buf[1] == hed_pkg::CH_HASH);
    assign w_hex      = (r_buf[2] == hed_pkg::CH_XL) || (r_buf[2] == hed_pkg::CH_XU);

    always_comb begin
        w_body = '0;
        for (int i = 0; i < 6; i++) begin
            if (i + 1 < BUF_DEPTH) w_body[i] = r_buf[i+1];
        end
    end

    assign w_ent = hed_pkg::ent_lookup(w_body, 8'(r_found - CNT_W'(1)));

    // Number digit step
    assign w_dig    = hed_pkg::digit_val(r_p[0]);
    assign w_dig_ok = (r_plen != '0) && (w_dig < (r_hex ? 5'd16 : 5'd10));
    assign w_acc_next = r_hex ? ({1'b0, r_acc, 4'b0} + 37'(w_dig))
                              : ({2'b0, r_acc, 3'b0} + {4'b0, r_acc, 1'b0} + 37'(w_dig));

    assign w_cp = r_ovf ? 32'hFFFF_FFFF : (r_neg ? (32'd0 - r_acc) : r_acc);

    always_comb begin
        w_utf   = '0;
        w_utf_n = 2'd1;
        if (w_cp < 32'h80) begin
            w_utf[0] = w_cp[7:0];
        end else if (w_cp < 32'h800) begin
            w_utf[0] = 8'hC0 | {3'b0, w_cp[10:6]};
            w_utf[1] = 8'h80 | {2'b0, w_cp[5:0]};
            w_utf_n  = 2'd2;
        end else if (w_cp < 32'h10000) begin
            w_utf[0] = 8'hE0 | {4'b0, w_cp[15:12]};
            w_utf[1] = 8'h80 | {2'b0, w_cp[11:6]};
            w_utf[2] = 8'h80 | {2'b0, w_cp[5:0]};
            w_utf_n  = 2'd3;
        end else begin
            w_utf[0] = hed_pkg::CH_QMARK;
        end
    end

    assign w_out_free = !r_out_v || i_out_ready;
    assign w_can_emit = !r_pend_v || w_out_free;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            hed_pkg::ST_IDLE: begin
                if (i_item_valid) n_state = hed_pkg::ST_SCAN;
            end
            hed_pkg::ST_SCAN: begin
                if (r_cnt == '0) n_state = hed_pkg::ST_FLUSH;
                else if (r_buf[0] != hed_pkg::CH_AMP) n_state = hed_pkg::ST_SCAN;
                else if (w_found_v) n_state = w_is_num ? hed_pkg::ST_NUM_WS : hed_pkg::ST_NAME;
                else if (r_cnt >= CNT_W'(BUF_DEPTH) || r_eot) n_state = hed_pkg::ST_SCAN;
                else n_state = hed_pkg::ST_FLUSH;
            end
            hed_pkg::ST_NAME: begin
                if (w_ent.hit) n_state = hed_pkg::ST_EXPAND;
                else if (w_can_emit) n_state = hed_pkg::ST_SCAN;
            end
            hed_pkg::ST_NUM_WS: begin
                if (!(r_plen != '0 && hed_pkg::is_ws(r_p[0]))) n_state = hed_pkg::ST_NUM_SIGN;
            end
            hed_pkg::ST_NUM_SIGN: n_state = hed_pkg::ST_NUM_PFX;
            hed_pkg::ST_NUM_PFX:  n_state = hed_pkg::ST_NUM_DIG;
            hed_pkg::ST_NUM_DIG: begin
                if (!w_dig_ok) n_state = hed_pkg::ST_NUM_END;
            end
            hed_pkg::ST_NUM_END: begin
                if (w_cp != 32'd0) n_state = hed_pkg::ST_EXPAND;
                else if (w_can_emit) n_state = hed_pkg::ST_SCAN;
            end
            hed_pkg::ST_EXPAND: begin
                if (r_exp_i == r_exp_n) n_state = hed_pkg::ST_SCAN;
            end
            hed_pkg::ST_FLUSH: begin
                if (!r_pend_v || w_out_free) n_state = hed_pkg::ST_IDLE;
            end
            default: n_state = hed_pkg::ST_IDLE;
        endcase
    end

    // Actions
    always_comb begin
        o_item_take = 1'b0;
        w_do_emit   = 1'b0;
        w_emit_byte = hed_pkg::CH_AMP;
        w_drop_en   = 1'b0;
        w_drop_n    = CNT_W'(1);
        w_flush_out = 1'b0;
        case (r_state)
            hed_pkg::ST_IDLE: o_item_take = i_item_valid;
            hed_pkg::ST_SCAN: begin
                if (r_cnt != '0 && r_buf[0] != hed_pkg::CH_AMP) begin
                    w_do_emit   = w_can_emit;
                    w_emit_byte = r_buf[0];
                    w_drop_en   = w_can_emit;
                end else if (w_amp_head && !w_found_v &&
                             (r_cnt >= CNT_W'(BUF_DEPTH) || r_eot)) begin
                    w_do_emit = w_can_emit;
                    w_drop_en = w_can_emit;
                end
            end
            hed_pkg::ST_NAME: begin
                if (!w_ent.hit) begin
                    w_do_emit = w_can_emit;
                    w_drop_en = w_can_emit;
                end
            end
            hed_pkg::ST_NUM_END: begin
                if (w_cp == 32'd0) begin
                    w_do_emit = w_can_emit;
                    w_drop_en = w_can_emit;
                end
            end
            hed_pkg::ST_EXPAND: begin
                if (r_exp_i == r_exp_n) begin
                    w_drop_en = 1'b1;
                    w_drop_n  = r_drop;
                end else begin
                    w_do_emit   = w_can_emit;
                    w_emit_byte = r_exp[r_exp_i];
                end
            end
            hed_pkg::ST_FLUSH: w_flush_out = r_pend_v && w_out_free;
            default: ;
        endcase
    end

    // Buffer after dropping w_drop_n bytes from the front
    always_comb begin
        for (int k = 0; k < BUF_DEPTH; k++) begin
            n_buf[k] = r_buf[k];
            for (int j = 0; j < BUF_DEPTH; j++) begin
                if (j == k + int'(w_drop_n)) n_buf[k] = r_buf[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= hed_pkg::ST_IDLE;
            r_cnt    <= '0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_item_take) r_cnt <= r_cnt + CNT_W'(1);
            else if (w_drop_en) r_cnt <= (w_drop_n >= r_cnt) ? '0 : r_cnt - w_drop_n;
            if (w_flush_out || (w_do_emit && r_pend_v)) r_out_v <= 1'b1;
            else if (r_out_v && i_out_ready) r_out_v <= 1'b0;
            if (w_do_emit) r_pend_v <= 1'b1;
            else if (w_flush_out) r_pend_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_item_take) begin
            r_buf[r_cnt[IDX_W-1:0]] <= i_item.data;
            r_eot                   <= i_item.eot;
        end else if (w_drop_en) begin
            r_buf <= n_buf;
        end

        if (w_do_emit) begin
            r_pend <= w_emit_byte;
            if (r_pend_v) begin
                r_out  <= r_pend;
                r_last <= 1'b0;
            end
        end
        if (w_flush_out) begin
            r_out  <= r_pend;
            r_last <= 1'b1;
        end

        case (r_state)
            hed_pkg::ST_SCAN: begin
                r_found <= w_found;
                r_hex   <= w_hex;
                r_acc   <= '0;
                r_neg   <= 1'b0;
                r_ovf   <= 1'b0;
                r_plen  <= w_found - (w_hex ? CNT_W'(3) : CNT_W'(2));
                for (int k = 0; k < BUF_DEPTH; k++) begin
                    r_p[k] <= 8'h00;
                    if (w_hex) begin
                        if (k + 3 < BUF_DEPTH) r_p[k] <= r_buf[k+3];
                    end else begin
                        if (k + 2 < BUF_DEPTH) r_p[k] <= r_buf[k+2];
                    end
                end
            end
            hed_pkg::ST_NAME: begin
                r_exp   <= w_ent.b;
                r_exp_n <= w_ent.n;
                r_exp_i <= 2'd0;
                r_drop  <= r_found + CNT_W'(1);
            end
            hed_pkg::ST_NUM_WS: begin
                if (r_plen != '0 && hed_pkg::is_ws(r_p[0])) begin
                    for (int k = 0; k + 1 < BUF_DEPTH; k++) r_p[k] <= r_p[k+1];
                    r_plen <= r_plen - CNT_W'(1);
                end
            end
            hed_pkg::ST_NUM_SIGN: begin
                if (r_plen != '0 &&
                    (r_p[0] == hed_pkg::CH_PLUS || r_p[0] == hed_pkg::CH_MINUS)) begin
                    r_neg <= (r_p[0] == hed_pkg::CH_MINUS);
                    for (int k = 0; k + 1 < BUF_DEPTH; k++) r_p[k] <= r_p[k+1];
                    r_plen <= r_plen - CNT_W'(1);
                end
            end
            hed_pkg::ST_NUM_PFX: begin
                if (r_hex && r_plen >= CNT_W'(2) && r_p[0] == hed_pkg::CH_ZERO &&
                    (r_p[1] == hed_pkg::CH_XL || r_p[1] == hed_pkg::CH_XU)) begin
                    for (int k = 0; k + 2 < BUF_DEPTH; k++) r_p[k] <= r_p[k+2];
                    r_plen <= r_plen - CNT_W'(2);
                end
            end
            hed_pkg::ST_NUM_DIG: begin
                if (w_dig_ok) begin
                    if (!r_ovf) begin
                        r_acc <= w_acc_next[31:0];
                        if (w_acc_next[36:32] != 5'd0) r_ovf <= 1'b1;
                    end
                    for (int k = 0; k + 1 < BUF_DEPTH; k++) r_p[k] <= r_p[k+1];
                    r_plen <= r_plen - CNT_W'(1);
                end
            end
            hed_pkg::ST_NUM_END: begin
                r_exp   <= w_utf;
                r_exp_n <= w_utf_n;
                r_exp_i <= 2'd0;
                r_drop  <= r_found + CNT_W'(1);
            end
            hed_pkg::ST_EXPAND: begin
                if (w_do_emit) r_exp_i <= r_exp_i + 2'd1;
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_out_v;
    assign o_out_byte  = r_out;
    assign o_run_last  = r_last;

endmodule

>>> hw/rtl/html_entity_decoder_unit.sv
// Top level of the HTML character entity decoder.
//
//  channel | direction | transfer when              | payload
//  --------+-----------+----------------------------+------------------------------
//  in      | into unit | i_in_valid & o_in_ready    | i_in_byte, i_end_of_text
//  out     | from unit | o_out_valid & i_out_ready  | o_out_byte, o_run_last
//
// Each byte leaves the queue into the lookahead buffer and is scanned; a byte passed through
// or emitted as a literal '&' goes out from the scan state, and the run closes through flush.
// A named entity passes through name lookup and expansion of its replacement bytes; a numeric
// one steps through leading spaces, sign, prefix and digits, then expands its UTF-8 bytes.
// Reset (i_rst_n low at a clock edge) empties the queue and the lookahead buffer.
// The input queue holds two transfers, so it accepts up to two while the engine
// waits on a stalled output; the last byte of a run is held until its run ends.
module html_entity_decoder_unit #(
    parameter int SEMI_WINDOW = 10
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_end_of_text,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_run_last
);

    logic           w_item_valid;
    hed_pkg::t_item w_item;
    logic           w_take;

    // Accept and queue input transfers.
    hed_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_in_byte     (i_in_byte),
        .i_end_of_text (i_end_of_text),
        .o_item_valid  (w_item_valid),
        .o_item        (w_item),
        .i_item_take   (w_take)
    );

    // Decode one queued byte at a time and stage the output.
    hed_back #(
        .SEMI_WINDOW (SEMI_WINDOW)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (w_item_valid),
        .i_item       (w_item),
        .o_item_take  (w_take),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_byte   (o_out_byte),
        .o_run_last   (o_run_last)
    );

    // The engine pops only a queued item.
    a_take_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |-> w_item_valid)
        else $error("engine popped an empty queue");

    // One item at a time: a pop is always followed by a scan cycle.
    a_take_spaced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |=> !w_take)
        else $error("engine popped two items back to back");

    // A transfer into an empty queue is visible on the next cycle.
    a_push_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && !w_item_valid) |=> w_item_valid)
        else $error("queued transfer lost");

endmodule

>>> dv/hed_decode_checker.sv
// Monitor, byte-level decode predictor and output comparison for the entity decoder.
`timescale 1ns / 1ps

module hed_decode_checker #(
    parameter int SEMI_WINDOW = 10
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_end_of_text,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [7:0] i_out_byte,
    input  logic       i_run_last,
    output int         o_fail_count,
    output int         o_pending
);

    localparam int DEPTH = SEMI_WINDOW + 1;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } t_dec_byte;

    t_dec_byte  expected_bytes[$];
    logic [7:0] pend_buf[DEPTH];
    int         pend_cnt;

    assign o_pending = expected_bytes.size();

    function automatic logic is_space(input logic [7:0] c);
        return c == hed_pkg::CH_SPACE || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic int hex_digit(input logic [7:0] c);
        if (c >= "0" && c <= "9") return c - "0";
        if (c >= "a" && c <= "f") return c - "a" + 10;
        if (c >= "A" && c <= "F") return c - "A" + 10;
        return 99;
    endfunction

    // Number as a 32-bit strtoul sees it; body bytes pend_buf[pos +: len].
    function automatic logic [31:0] read_number(input int pos, input int len, input int base);
        int          i;
        int          d;
        logic        neg;
        logic        ovf;
        logic [63:0] acc;
        i   = 0;
        neg = 0;
        ovf = 0;
        acc = '0;
        while (i < len && is_space(pend_buf[pos + i])) i++;
        if (i < len && (pend_buf[pos + i] == hed_pkg::CH_PLUS ||
                        pend_buf[pos + i] == hed_pkg::CH_MINUS)) begin
            neg = pend_buf[pos + i] == hed_pkg::CH_MINUS;
            i++;
        end
        if (base == 16 && i + 1 < len && pend_buf[pos + i] == hed_pkg::CH_ZERO
                && (pend_buf[pos + i + 1] == hed_pkg::CH_XL ||
                    pend_buf[pos + i + 1] == hed_pkg::CH_XU))
            i += 2;
        for (; i < len; i++) begin
            d = hex_digit(pend_buf[pos + i]);
            if (d >= base) break;
            if (!ovf) begin
                acc = acc * base + d;
                if (acc > 64'hFFFF_FFFF) ovf = 1;
            end
        end
        if (ovf) return 32'hFFFF_FFFF;
        if (neg) return 32'd0 - acc[31:0];
        return acc[31:0];
    endfunction

    // Body is pend_buf[1 +: len]; returns byte count or -1 when not an entity.
    function automatic int decode_body(input int len, output logic [7:0] d[3]);
        logic [31:0] cp;
        int          nl;
        int          vl;
        logic        ok;
        for (int j = 0; j < 3; j++) d[j] = '0;
        if (len > 1 && pend_buf[1] == hed_pkg::CH_HASH) begin
            if (pend_buf[2] == hed_pkg::CH_XL || pend_buf[2] == hed_pkg::CH_XU)
                cp = read_number(3, len - 2, 16);
            else cp = read_number(2, len - 1, 10);
            if (cp == 0) return -1;
            if (cp < 32'h80) begin
                d[0] = cp[7:0];
                return 1;
            end
            if (cp < 32'h800) begin
                d[0] = 8'hC0 | {3'b0, cp[10:6]};
                d[1] = 8'h80 | {2'b0, cp[5:0]};
                return 2;
            end
            if (cp < 32'h10000) begin
                d[0] = 8'hE0 | {4'b0, cp[15:12]};
                d[1] = 8'h80 | {2'b0, cp[11:6]};
                d[2] = 8'h80 | {2'b0, cp[5:0]};
                return 3;
            end
            d[0] = hed_pkg::CH_QMARK;
            return 1;
        end
        for (int k = 0; k < hed_pkg::NUM_ENT; k++) begin
            nl = 0;
            vl = 0;
            for (int j = 0; j < 6; j++) if (hed_pkg::ENT_NAME[k][8*j +: 8] != 0) nl = j + 1;
            for (int j = 0; j < 3; j++) if (hed_pkg::ENT_VAL[k][8*j +: 8] != 0) vl = j + 1;
            ok = nl == len;
            for (int i = 0; i < nl; i++)
                if (ok && pend_buf[1 + i] != hed_pkg::ENT_NAME[k][8*(nl-1-i) +: 8]) ok = 0;
            if (ok) begin
                for (int j = 0; j < vl; j++) d[j] = hed_pkg::ENT_VAL[k][8*(vl-1-j) +: 8];
                return vl;
            end
        end
        return -1;
    endfunction

    function automatic void drop_front(input int n);
        if (n >= pend_cnt) begin
            pend_cnt = 0;
            return;
        end
        for (int i = 0; i < pend_cnt - n; i++) pend_buf[i] = pend_buf[i + n];
        pend_cnt -= n;
    endfunction

    function automatic void push_byte(input logic [7:0] b);
        t_dec_byte e;
        e.data = b;
        e.last = 0;
        expected_bytes = {expected_bytes, e};
    endfunction

    function automatic void decode_step(input logic [7:0] b, input logic eot);
        int         start;
        int         semi;
        int         r;
        logic [7:0] d[3];
        start = expected_bytes.size();
        if (pend_cnt < DEPTH) begin
            pend_buf[pend_cnt] = b;
            pend_cnt++;
        end
        while (pend_cnt > 0) begin
            if (pend_buf[0] != hed_pkg::CH_AMP) begin
                push_byte(pend_buf[0]);
                drop_front(1);
                continue;
            end
            semi = 0;
            for (int s = 1; s < pend_cnt; s++)
                if (semi == 0 && pend_buf[s] == hed_pkg::CH_SEMI) semi = s;
            if (semi != 0) begin
                r = decode_body(semi - 1, d);
                if (r >= 0) begin
                    for (int j = 0; j < r; j++) push_byte(d[j]);
                    drop_front(semi + 1);
                end else begin
                    push_byte(hed_pkg::CH_AMP);
                    drop_front(1);
                end
                continue;
            end
            if (pend_cnt >= DEPTH || eot) begin
                push_byte(hed_pkg::CH_AMP);
                drop_front(1);
                continue;
            end
            break;
        end
        if (expected_bytes.size() > start) expected_bytes[$].last = 1;
    endfunction

    always @(posedge i_clk) begin
        t_dec_byte e;
        if (!i_rst_n) begin
            expected_bytes.delete();
            pend_cnt     = 0;
            o_fail_count = 0;
        end else begin
            if (i_in_valid && i_in_ready) decode_step(i_in_byte, i_end_of_text);
            if (i_out_valid && i_out_ready) begin
                if (expected_bytes.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: unexpected output byte %h last %b",
                             $time, i_out_byte, i_run_last);
                end else begin
                    e = expected_bytes.pop_front();
                    if (e.data !== i_out_byte) begin
                        o_fail_count++;
                        $display("%0t: out_byte expected %h actual %h", $time, e.data, i_out_byte);
                    end
                    if (e.last !== i_run_last) begin
                        o_fail_count++;
                        $display("%0t: run_last expected %b actual %b", $time, e.last, i_run_last);
                    end
                end
            end
        end
    end

endmodule

>>> dv/tb_html_entity_decoder_unit.sv
// Stimulus and verdict for the HTML entity decoder unit.
`timescale 1ns / 1ps

module tb_html_entity_decoder_unit;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RANDOM_ITEMS   = 420;

    logic       i_clk = 0;
    logic       i_rst_n = 0;
    logic       i_in_valid = 0;
    logic       o_in_ready;
    logic [7:0] i_in_byte = 0;
    logic       i_end_of_text = 0;
    logic       o_out_valid;
    logic       i_out_ready = 0;
    logic [7:0] o_out_byte;
    logic       o_run_last;
    int         fail_count;
    int         pending;
    int         idle_cycles = 0;
    int         sent = 0;
    int         sink_stall = 0;
    bit         no_idle = 0;   // stretches of back-to-back traffic on both sides

    always #10 i_clk = ~i_clk;

    html_entity_decoder_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_byte    (i_in_byte),
        .i_end_of_text(i_end_of_text),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_byte   (o_out_byte),
        .o_run_last   (o_run_last)
    );

    hed_decode_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_byte    (i_in_byte),
        .i_end_of_text(i_end_of_text),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_byte   (o_out_byte),
        .i_run_last   (o_run_last),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Output side: after each transfer, draw a random stall of i_out_ready; none while no_idle is set.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 0;
        end else if (o_out_valid && i_out_ready) begin
            sink_stall = no_idle ? 0 : $urandom_range(0, 4);
            i_out_ready <= sink_stall == 0;
        end else if (sink_stall > 0) begin
            sink_stall--;
            i_out_ready <= sink_stall == 0;
        end else begin
            i_out_ready <= 1;
        end
    end

    // Watchdog: end the run after too many cycles without any transfer.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (i_rst_n) begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // Hold the byte on the input until the transfer happens.
    task automatic send_byte(input logic [7:0] b, input logic eot);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            i_in_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1;
        i_in_byte     <= b;
        i_end_of_text <= eot;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sent++;
        if ($urandom_range(0, 39) == 0) no_idle = !no_idle;
    endtask

    task automatic send_text(input string s, input bit eot);
        for (int i = 0; i < s.len(); i++) send_byte(s[i], eot && i == s.len() - 1);
    endtask

    // Entity name k of the table, spelled from the packed constant.
    function automatic string table_name(input int k);
        string s;
        s = "";
        for (int j = 5; j >= 0; j--)
            if (hed_pkg::ENT_NAME[k][8*j +: 8] != 0)
                s = {s, string'(hed_pkg::ENT_NAME[k][8*j +: 8])};
        return s;
    endfunction

    task automatic send_random_sequence();
        string s;
        int    kind;
        bit    eot;
        kind = $urandom_range(0, 9);
        eot  = $urandom_range(0, 7) == 0;
        case (kind)
            0, 1, 2: begin
                s = {"&", table_name($urandom_range(0, hed_pkg::NUM_ENT - 1)), ";"};
            end
            3: begin
                s = table_name($urandom_range(0, hed_pkg::NUM_ENT - 1));
                s = {"&", s.toupper(), ";"};
            end
            4: begin
                case ($urandom_range(0, 2))
                    0: s = $sformatf("&#%0d;", $urandom_range(0, 200));
                    1: s = $sformatf("&#%0d;", $urandom_range(0, 70000));
                    default: s = $sformatf("&#%0d;", $urandom_range(0, 99999999));
                endcase
            end
            5: begin
                case ($urandom_range(0, 3))
                    0: s = $sformatf("&#x%0h;", $urandom_range(0, 32'hFFF));
                    1: s = $sformatf("&#X%0H;", $urandom_range(0, 32'hFFFF));
                    2: s = $sformatf("&#x0x%0h;", $urandom_range(0, 32'h1FFFF));
                    default: s = $sformatf("&#x%0h;", $urandom_range(0, 32'hFFFFFFF));
                endcase
            end
            6: begin
                s = $sformatf("&#%s%s%0d%s;", $urandom_range(0, 1) ? " " : "",
                              $urandom_range(0, 1) ? "-" : "+", $urandom_range(0, 999),
                              $urandom_range(0, 1) ? "z" : "");
            end
            7: begin
                s = "&";
                repeat ($urandom_range(0, 12)) s = {s, string'(8'($urandom_range(97, 122)))};
            end
            default: begin
                // Raw bytes of any value, sometimes broken entities among them.
                repeat ($urandom_range(1, 6)) begin
                    case ($urandom_range(0, 5))
                        0: s = {s, "&"};
                        1: s = {s, ";"};
                        2: s = {s, "#"};
                        default: s = {s, " "};
                    endcase
                    if (s[s.len() - 1] == " ") s[s.len() - 1] = 8'($urandom_range(0, 255));
                end
            end
        endcase
        send_text(s, eot);
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;

        // Directed: named, numeric, zero, lone hash, no semicolon and end of text cases.
        send_text("a&amp;&lt;&shy;&hellip;", 0);
        send_text("&Ntilde;&rdquo;&Amp;", 0);
        send_text("&#65;&#x3B1;&#x20AC;&#X10000;&#-1;", 0);
        send_text("&#0;&#x;&#;&#x0x41;& #;&# \t+66z;", 0);
        send_text("&abcdefghijk;&#99999999;&#xFFFFFFF;", 0);
        send_text("x&&ltq&gt", 1);
        send_byte(8'hFF, 0);
        send_byte(8'h00, 1);
        send_text("&&&", 1);

        while (sent < RANDOM_ITEMS) send_random_sequence();
        send_text("&", 1);
        i_in_valid <= 0;

        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
